// File: src/ddfp_pkg.sv
// ----------------------------------------------------------------------------
// Decimal field parser package
// Shared constants, register indexes and configuration type.
// ----------------------------------------------------------------------------
package ddfp_pkg;

   localparam int FRAME_BYTES_DEF = 128;
   localparam int FIELD_CHARS_DEF = 5;

   localparam int BYTE_W    = 8;
   localparam int COUNT_W   = 3;
   localparam int FIELDS_W  = 5;
   localparam int SKIP_W    = 4;
   localparam int ACC_W     = 17;
   localparam int PROD_W    = 20;
   localparam int DIGIT_W   = 4;
   localparam int POINT_W   = 2;
   localparam int CHAN_W    = 6;
   localparam int VALUE_W   = 21;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 5;

   localparam logic [BYTE_W-1:0] CHAR_SEP   = 8'h5F;  // '_'
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;  // '.'
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;  // '9'

   localparam logic [ACC_W-1:0]  INT_LIMIT  = 17'd99999;
   localparam logic [BYTE_W-1:0] FRAME_OVER = 8'hFF;

   // fraction progress of the open field
   localparam logic [POINT_W-1:0] PT_NONE  = 2'd0;
   localparam logic [POINT_W-1:0] PT_SEEN  = 2'd1;
   localparam logic [POINT_W-1:0] PT_TAKEN = 2'd2;

   localparam logic [SKIP_W-1:0]   HEADER_SKIP_RST  = 4'd4;
   localparam logic [FIELDS_W-1:0] FIELD_COUNT_RST  = 5'd12;
   localparam logic [FIELDS_W-1:0] CHANNEL_BASE_RST = 5'd0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEADER_SKIP  = 2'd0,
      CSR_FIELD_COUNT  = 2'd1,
      CSR_CHANNEL_BASE = 2'd2
   } csr_reg_type;

   typedef struct packed {
      logic [SKIP_W-1:0]   header_skip;
      logic [FIELDS_W-1:0] field_count;
      logic [FIELDS_W-1:0] channel_base;
   } cfg_type;

endpackage

// File: src/ddfp_field_scan.sv
// ----------------------------------------------------------------------------
// Decimal field parser: field scanner
// Holds the frame and field state and scans one byte per step, producing at
// most one decoded field.
// ----------------------------------------------------------------------------
module ddfp_field_scan #(
   parameter int FRAME_BYTES = ddfp_pkg::FRAME_BYTES_DEF,
   parameter int FIELD_CHARS = ddfp_pkg::FIELD_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [ddfp_pkg::BYTE_W-1:0]        data_byte,
   input  logic                               frame_start,
   input  logic                               frame_end,
   input  ddfp_pkg::cfg_type                  cfg,
   output logic                               emit,
   output logic [ddfp_pkg::CHAN_W-1:0]        channel,
   output logic signed [ddfp_pkg::VALUE_W-1:0] value_tenths
);

   localparam logic [ddfp_pkg::BYTE_W-1:0]  FRAME_LIMIT = ddfp_pkg::BYTE_W'(FRAME_BYTES);
   localparam logic [ddfp_pkg::COUNT_W-1:0] CHAR_LIMIT  = ddfp_pkg::COUNT_W'(FIELD_CHARS);

   logic [ddfp_pkg::BYTE_W-1:0]   byte_index_ff, byte_index_in;
   logic [ddfp_pkg::COUNT_W-1:0]  char_count_ff, char_count_in;
   logic [ddfp_pkg::FIELDS_W-1:0] fields_done_ff, fields_done_in;
   logic [ddfp_pkg::ACC_W-1:0]    accum_ff, accum_in;
   logic [ddfp_pkg::DIGIT_W-1:0]  tenths_ff, tenths_in;
   logic [ddfp_pkg::POINT_W-1:0]  point_ff, point_in;
   logic                          negative_ff, negative_in;
   logic                          stopped_ff, stopped_in;

   // state after frame start, then after the character is fed
   logic [ddfp_pkg::BYTE_W-1:0]   bi0;
   logic [ddfp_pkg::COUNT_W-1:0]  cc0, cc1;
   logic [ddfp_pkg::FIELDS_W-1:0] fd0;
   logic [ddfp_pkg::ACC_W-1:0]    acc0, acc1;
   logic [ddfp_pkg::DIGIT_W-1:0]  td0, td1;
   logic [ddfp_pkg::POINT_W-1:0]  pt0, pt1;
   logic                          neg0, neg1, stop0, stop1;

   logic                          active, feed, emit_mid, emit_end, is_digit;
   logic [ddfp_pkg::DIGIT_W-1:0]  digit;
   logic [ddfp_pkg::PROD_W-1:0]   acc_prod;
   logic [ddfp_pkg::VALUE_W-1:0]  mag;

   always_comb begin
      if (frame_start) begin
         bi0   = '0;
         fd0   = '0;
         cc0   = '0;
         acc0  = '0;
         td0   = '0;
         pt0   = ddfp_pkg::PT_NONE;
         neg0  = 1'b0;
         stop0 = 1'b0;
      end else begin
         bi0   = byte_index_ff;
         fd0   = fields_done_ff;
         cc0   = char_count_ff;
         acc0  = accum_ff;
         td0   = tenths_ff;
         pt0   = point_ff;
         neg0  = negative_ff;
         stop0 = stopped_ff;
      end
   end

   assign active = (bi0 < FRAME_LIMIT) && (bi0 != ddfp_pkg::FRAME_OVER) &&
                   (fd0 < cfg.field_count) &&
                   (bi0 >= ddfp_pkg::BYTE_W'(cfg.header_skip));
   assign feed   = active && (data_byte != ddfp_pkg::CHAR_SEP) && (cc0 < CHAR_LIMIT);

   assign is_digit = (data_byte >= ddfp_pkg::CHAR_ZERO) && (data_byte <= ddfp_pkg::CHAR_NINE);
   assign digit    = ddfp_pkg::DIGIT_W'(data_byte - ddfp_pkg::CHAR_ZERO);
   assign acc_prod = (ddfp_pkg::PROD_W'(acc0) << 3) + (ddfp_pkg::PROD_W'(acc0) << 1) +
                     ddfp_pkg::PROD_W'(digit);

   // feed one character into the open field
   always_comb begin
      cc1   = cc0;
      acc1  = acc0;
      td1   = td0;
      pt1   = pt0;
      neg1  = neg0;
      stop1 = stop0;
      if (feed) begin
         cc1 = cc0 + 1'b1;
         if (!stop0) begin
            if ((cc0 == '0) &&
                (data_byte == ddfp_pkg::CHAR_PLUS || data_byte == ddfp_pkg::CHAR_MINUS)) begin
               neg1 = (data_byte == ddfp_pkg::CHAR_MINUS);
            end else if (is_digit) begin
               if (pt0 == ddfp_pkg::PT_NONE) begin
                  if (acc_prod > ddfp_pkg::PROD_W'(ddfp_pkg::INT_LIMIT)) begin
                     acc1 = ddfp_pkg::INT_LIMIT;
                  end else begin
                     acc1 = acc_prod[ddfp_pkg::ACC_W-1:0];
                  end
               end else if (pt0 == ddfp_pkg::PT_SEEN) begin
                  td1 = digit;
                  pt1 = ddfp_pkg::PT_TAKEN;
               end
            end else if (data_byte == ddfp_pkg::CHAR_POINT && pt0 == ddfp_pkg::PT_NONE) begin
               pt1 = ddfp_pkg::PT_SEEN;
            end else begin
               stop1 = 1'b1;
            end
         end
      end
   end

   // a field closes on a separator or full field, or on the last byte of the frame
   assign emit_mid = active && !feed;
   assign emit_end = frame_end && !emit_mid && (cc1 != '0) && (fd0 < cfg.field_count);
   assign emit     = emit_mid || emit_end;

   assign mag = (ddfp_pkg::VALUE_W'(acc1) << 3) + (ddfp_pkg::VALUE_W'(acc1) << 1) +
                ddfp_pkg::VALUE_W'(td1);
   assign value_tenths = neg1 ? -mag : mag;
   assign channel      = ddfp_pkg::CHAN_W'(cfg.channel_base) + ddfp_pkg::CHAN_W'(fd0);

   always_comb begin
      fields_done_in = emit ? fd0 + 1'b1 : fd0;
      byte_index_in  = (bi0 != ddfp_pkg::FRAME_OVER) ? bi0 + 1'b1 : bi0;
      char_count_in  = cc1;
      accum_in       = acc1;
      tenths_in      = td1;
      point_in       = pt1;
      negative_in    = neg1;
      stopped_in     = stop1;
      if (emit || frame_end) begin
         char_count_in = '0;
         accum_in      = '0;
         tenths_in     = '0;
         point_in      = ddfp_pkg::PT_NONE;
         negative_in   = 1'b0;
         stopped_in    = 1'b0;
      end
      if (frame_end) begin
         byte_index_in = ddfp_pkg::FRAME_OVER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff  <= '0;
         char_count_ff  <= '0;
         fields_done_ff <= '0;
         accum_ff       <= '0;
         tenths_ff      <= '0;
         point_ff       <= ddfp_pkg::PT_NONE;
         negative_ff    <= 1'b0;
         stopped_ff     <= 1'b0;
      end else if (step) begin
         byte_index_ff  <= byte_index_in;
         char_count_ff  <= char_count_in;
         fields_done_ff <= fields_done_in;
         accum_ff       <= accum_in;
         tenths_ff      <= tenths_in;
         point_ff       <= point_in;
         negative_ff    <= negative_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule

// File: src/delimited_decimal_field_parser.sv
// ----------------------------------------------------------------------------
// Delimited decimal field parser
// Splits a received frame into '_'-separated decimal fields and returns each
// as a channel number and a value in tenths.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle while the input is not stalled, and passes
// the byte that closes a field through the input register and the scanner
// logic into the result register as a field value. A byte
// that closes no field leaves no result. The result register frees the input
// side, so bytes keep flowing while a result waits until one that closes a
// field reaches the input register; that byte is held there, and the input
// stalls, until the waiting result is taken. Configuration writes are always
// ready and should be made while the parser is idle.
// ----------------------------------------------------------------------------
module delimited_decimal_field_parser #(
   parameter int FRAME_BYTES = ddfp_pkg::FRAME_BYTES_DEF,
   parameter int FIELD_CHARS = ddfp_pkg::FIELD_CHARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ddfp_pkg::BYTE_W-1:0]         req_data_byte,
   input  logic                                req_frame_start,
   input  logic                                req_frame_end,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ddfp_pkg::CHAN_W-1:0]         rsp_channel,
   output logic signed [ddfp_pkg::VALUE_W-1:0] rsp_value_tenths,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ddfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddfp_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   ddfp_pkg::cfg_type cfg_ff;

   logic                               in_valid_ff;
   logic [ddfp_pkg::BYTE_W-1:0]        in_byte_ff;
   logic                               in_start_ff;
   logic                               in_end_ff;

   logic                               rsp_valid_ff;
   logic [ddfp_pkg::CHAN_W-1:0]        rsp_channel_ff;
   logic signed [ddfp_pkg::VALUE_W-1:0] rsp_value_ff;

   logic                               advance;
   logic                               out_free;
   logic                               scan_emit;
   logic [ddfp_pkg::CHAN_W-1:0]        scan_channel;
   logic signed [ddfp_pkg::VALUE_W-1:0] scan_value;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_skip  <= ddfp_pkg::HEADER_SKIP_RST;
         cfg_ff.field_count  <= ddfp_pkg::FIELD_COUNT_RST;
         cfg_ff.channel_base <= ddfp_pkg::CHANNEL_BASE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ddfp_pkg::CSR_HEADER_SKIP:
               cfg_ff.header_skip <= csr_wdata[ddfp_pkg::SKIP_W-1:0];
            ddfp_pkg::CSR_FIELD_COUNT:
               cfg_ff.field_count <= csr_wdata;
            ddfp_pkg::CSR_CHANNEL_BASE:
               cfg_ff.channel_base <= csr_wdata;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // the held item moves on unless it has a field to hand over and the result
   // register is still full
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!scan_emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_data_byte;
         in_start_ff <= req_frame_start;
         in_end_ff   <= req_frame_end;
      end
   end

   ddfp_field_scan #(
      .FRAME_BYTES(FRAME_BYTES),
      .FIELD_CHARS(FIELD_CHARS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (in_byte_ff),
      .frame_start (in_start_ff),
      .frame_end   (in_end_ff),
      .cfg         (cfg_ff),
      .emit        (scan_emit),
      .channel     (scan_channel),
      .value_tenths(scan_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && scan_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && scan_emit) begin
         rsp_channel_ff <= scan_channel;
         rsp_value_ff   <= scan_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_value_tenths = rsp_value_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with no item held");

   a_result_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && scan_emit))
      else $error("result appeared without a closed field");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (advance && scan_emit) |-> out_free)
      else $error("field written over a waiting result");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff <= 21'sd999999 && rsp_value_ff >= -21'sd999999))
      else $error("field value out of range");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal field parser testbench
// Feeds reply frames byte by byte under random sender gaps and receiver
// stalls, predicts every decoded field and checks channel and value in order.
// ----------------------------------------------------------------------------
module tb_top;
   import ddfp_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef logic [BYTE_W-1:0] octet_t;

   typedef struct {
      logic [CHAN_W-1:0]         channel;
      logic signed [VALUE_W-1:0] value_tenths;
   } field_result_t;

   // Tracks the parser's frame state and queues the fields it should emit.
   class field_scoreboard;
      logic [SKIP_W-1:0]   header_skip;
      logic [FIELDS_W-1:0] field_count;
      logic [FIELDS_W-1:0] channel_base;
      logic [BYTE_W-1:0]   byte_index;
      logic [COUNT_W-1:0]  char_count;
      logic [FIELDS_W-1:0] fields_done;
      logic [ACC_W-1:0]    integer_accum;
      logic [DIGIT_W-1:0]  tenths_digit;
      logic [POINT_W-1:0]  after_point;
      logic                is_negative;
      logic                scan_stopped;
      field_result_t       expected_q[$];
      int                  errors;

      function new();
         header_skip  = HEADER_SKIP_RST;
         field_count  = FIELD_COUNT_RST;
         channel_base = CHANNEL_BASE_RST;
         byte_index   = '0;
         fields_done  = '0;
         errors       = 0;
         clear_field();
      endfunction

      function void clear_field();
         char_count    = '0;
         integer_accum = '0;
         tenths_digit  = '0;
         after_point   = PT_NONE;
         is_negative   = 1'b0;
         scan_stopped  = 1'b0;
      endfunction

      function void set_register(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_HEADER_SKIP:  header_skip  = data[SKIP_W-1:0];
            CSR_FIELD_COUNT:  field_count  = data;
            CSR_CHANNEL_BASE: channel_base = data;
            default: ;
         endcase
      endfunction

      function void close_field();
         field_result_t      r;
         logic [VALUE_W-1:0] mag;
         mag = integer_accum * 21'd10 + tenths_digit;
         r.channel      = CHAN_W'(channel_base) + CHAN_W'(fields_done);
         r.value_tenths = is_negative ? -mag : mag;
         expected_q.push_back(r);
         fields_done = fields_done + 1'b1;
         clear_field();
      endfunction

      function void note_byte(octet_t c, bit is_start, bit is_last);
         bit                 closed;
         bit                 lead;
         logic [VALUE_W-1:0] grown;
         closed = 1'b0;
         if (is_start) begin
            byte_index  = '0;
            fields_done = '0;
            clear_field();
         end
         if (byte_index < FRAME_BYTES_DEF && byte_index != FRAME_OVER &&
             fields_done < field_count && byte_index >= header_skip) begin
            if (c != CHAR_SEP && char_count < FIELD_CHARS_DEF) begin
               lead = (char_count == 0);
               char_count = char_count + 1'b1;
               if (!scan_stopped) begin
                  if (lead && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                     is_negative = (c == CHAR_MINUS);
                  end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                     if (after_point == PT_NONE) begin
                        grown = integer_accum * 21'd10 + (c - CHAR_ZERO);
                        integer_accum = (grown > INT_LIMIT) ? INT_LIMIT : grown[ACC_W-1:0];
                     end else if (after_point == PT_SEEN) begin
                        tenths_digit = DIGIT_W'(c - CHAR_ZERO);
                        after_point  = PT_TAKEN;
                     end
                  end else if (c == CHAR_POINT && after_point == PT_NONE) begin
                     after_point = PT_SEEN;
                  end else begin
                     scan_stopped = 1'b1;
                  end
               end
            end else begin
               // separator or overfull field: this byte closes the field
               close_field();
               closed = 1'b1;
            end
         end
         if (byte_index != FRAME_OVER)
            byte_index = byte_index + 1'b1;
         if (is_last) begin
            if (!closed && char_count != 0 && fields_done < field_count)
               close_field();
            clear_field();
            byte_index = FRAME_OVER;
         end
      endfunction

      function void check_result(logic [CHAN_W-1:0] ch, logic signed [VALUE_W-1:0] val);
         field_result_t want;
         if (expected_q.size() == 0) begin
            $error("unexpected field: channel %0d value_tenths %0d", ch, val);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (ch !== want.channel) begin
            $error("channel: expected %0d, actual %0d", want.channel, ch);
            errors++;
         end
         if (val !== want.value_tenths) begin
            $error("value_tenths: expected %0d, actual %0d", want.value_tenths, val);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [BYTE_W-1:0]         req_data_byte;
   logic                      req_frame_start;
   logic                      req_frame_end;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [CHAN_W-1:0]         rsp_channel;
   logic signed [VALUE_W-1:0] rsp_value_tenths;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DAT_W-1:0]      csr_wdata;

   field_scoreboard parser_sb;
   octet_t          frame_q[$];
   int              items_sent = 0;
   int              burst_left = 0;
   int              cycle_count = 0;
   int              stall_mode = 0;
   int              stall_left = 0;

   delimited_decimal_field_parser dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .req_frame_end    (req_frame_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_channel      (rsp_channel),
      .rsp_value_tenths (rsp_value_tenths),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // Check results and stall in runs: free, light and heavy.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         parser_sb.check_result(rsp_channel, rsp_value_tenths);
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(8, 60);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 4) != 0);
      endcase
   end

   function automatic octet_t rand_digit();
      return CHAR_ZERO + octet_t'($urandom_range(0, 9));
   endfunction

   // Sender bursts: drop valid for a random gap when a burst runs out.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic send_byte(octet_t c, bit is_start, bit is_last);
      pace();
      req_valid       <= 1'b1;
      req_data_byte   <= c;
      req_frame_start <= is_start;
      req_frame_end   <= is_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parser_sb.note_byte(c, is_start, is_last);
      items_sent++;
   endtask

   task automatic send_frame(bit with_start, bit with_end);
      foreach (frame_q[i])
         send_byte(frame_q[i], with_start && i == 0, with_end && i == frame_q.size() - 1);
   endtask

   // Hold the sender until every field has arrived and the pipeline is empty.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (parser_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_reg_type idx, logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      parser_sb.set_register(idx, data);
   endtask

   task automatic configure(int skip, int count, int base);
      drain_results();
      write_csr(CSR_HEADER_SKIP, CSR_DAT_W'(skip));
      write_csr(CSR_FIELD_COUNT, CSR_DAT_W'(count));
      write_csr(CSR_CHANNEL_BASE, CSR_DAT_W'(base));
      csr_valid <= 1'b0;
   endtask

   // Append one field (or a bare separator): optional sign, digits, point, fraction, junk, closer.
   task automatic add_field();
      int used;
      used = 0;
      if ($urandom_range(0, 9) == 0) begin
         frame_q.push_back(CHAR_SEP);
         return;
      end
      if ($urandom_range(0, 3) == 0) begin
         frame_q.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
         used++;
      end
      repeat ($urandom_range(0, 5)) begin
         if (used < FIELD_CHARS_DEF) begin
            frame_q.push_back(rand_digit());
            used++;
         end
      end
      if ($urandom_range(0, 4) < 2 && used < FIELD_CHARS_DEF) begin
         frame_q.push_back(CHAR_POINT);
         used++;
         repeat ($urandom_range(0, 3)) begin
            if (used < FIELD_CHARS_DEF) begin
               frame_q.push_back(rand_digit());
               used++;
            end
         end
      end
      if ($urandom_range(0, 6) == 0 && used < FIELD_CHARS_DEF) begin
         frame_q.push_back(octet_t'($urandom_range(0, 255)));
         used++;
      end
      // a full field is closed by any byte
      if (used == FIELD_CHARS_DEF && $urandom_range(0, 1))
         frame_q.push_back(octet_t'($urandom_range(0, 255)));
      else
         frame_q.push_back(CHAR_SEP);
   endtask

   task automatic run_traffic(int count);
      int target;
      int kind;
      int hdr;
      target = items_sent + count;
      while (items_sent < target) begin
         kind = $urandom_range(0, 99);
         frame_q.delete();
         if (kind < 75) begin
            hdr = parser_sb.header_skip;
            if ($urandom_range(0, 9) == 0)
               hdr = $urandom_range(0, 15);
            repeat (hdr) frame_q.push_back(octet_t'($urandom_range(0, 255)));
            repeat ($urandom_range(1, parser_sb.field_count + 1)) add_field();
            // drop the last separator so the end byte closes an open field
            if (frame_q[frame_q.size() - 1] == CHAR_SEP && $urandom_range(0, 1))
               void'(frame_q.pop_back());
            send_frame(1'b1, $urandom_range(0, 9) != 0);
         end else if (kind < 85) begin
            repeat ($urandom_range(1, 20))
               frame_q.push_back($urandom_range(0, 1) ? rand_digit() :
                                 octet_t'($urandom_range(0, 255)));
            send_frame($urandom_range(0, 9) < 7, $urandom_range(0, 9) < 7);
         end else if (kind < 92) begin
            repeat ($urandom_range(1, 6)) frame_q.push_back(octet_t'($urandom_range(0, 255)));
            send_frame(1'b0, $urandom_range(0, 4) == 0);
         end else begin
            send_byte($urandom_range(0, 9) < 7 ? rand_digit() : octet_t'($urandom_range(0, 255)),
                      1'b1, 1'b1);
         end
         if ($urandom_range(0, 24) == 0)
            drain_results();
      end
   endtask

   initial begin
      parser_sb       = new();
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= '0;
      req_frame_start <= 1'b0;
      req_frame_end   <= 1'b0;
      rsp_stall       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_HEADER_SKIP;
      csr_wdata       <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Header, full field closed by a letter, minus with no integer digits,
      // sign not first, extra fraction digits, second point closed by frame end.
      frame_q = '{8'h00, 8'hFF, "x", "_",
                  "9", "9", "9", "9", "9", "Z",
                  "-", ".", "9", "_",
                  "+", "-", "_",
                  "1", ".", "2", "3", "_",
                  ".", ".", "5", "-"};
      send_frame(1'b1, 1'b1);
      send_byte("7", 1'b0, 1'b0);
      run_traffic(220);

      configure(0, 1, 31);
      run_traffic(220);

      configure(15, 16, 31);
      run_traffic(200);

      configure(0, 16, 0);
      frame_q.delete();
      repeat ($urandom_range(130, 270))
         frame_q.push_back($urandom_range(0, 5) == 0 ? CHAR_SEP :
                           ($urandom_range(0, 3) == 0 ? octet_t'($urandom_range(0, 255)) :
                            rand_digit()));
      send_frame(1'b1, 1'b1);
      run_traffic(120);

      repeat (3) begin
         configure($urandom_range(0, 15), $urandom_range(1, 16), $urandom_range(0, 31));
         run_traffic(160);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (parser_sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
